FILE: rtl/kvt_pkg.sv
// shared types, codes and character constants of the key/value tokenizer
package kvt_pkg;

    localparam int POS_BITS_DEFAULT = 16;
    localparam int POS_OUT_W        = 16;
    localparam int MAX_RESULTS      = 3;
    localparam int QUEUE_DEPTH      = MAX_RESULTS + 1;
    localparam int TDATA_W          = 48;
    localparam int TUSER_W          = 4;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_STRING = 3'd1,
        MODE_ESCAPE = 3'd2,
        MODE_NUMBER = 3'd3,
        MODE_IDENT  = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        K_DATA   = 4'd0,
        K_NUMBER = 4'd1,
        K_IDENT  = 4'd2,
        K_EQUAL  = 4'd3,
        K_COMMA  = 4'd4,
        K_SEMI   = 4'd5,
        K_COLON  = 4'd6,
        K_EOF    = 4'd7,
        K_ERROR  = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_UNKNOWN  = 2'd1,
        ERR_UNTERM   = 2'd2,
        ERR_OVERFLOW = 2'd3
    } err_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef struct packed {
        kind_t                  kind;
        logic                   has_char;
        logic [7:0]             char_out;
        logic                   token_done;
        logic [POS_OUT_W-1:0]   start_pos;
        logic [POS_OUT_W-1:0]   end_pos;
        err_t                   error_code;
        logic                   last_result;
    } rec_t;

    // records produced by one accepted byte
    typedef struct packed {
        logic                         valid;
        logic [1:0]                   count;
        rec_t [MAX_RESULTS-1:0]       recs;
    } lex_out_t;

endpackage

FILE: rtl/kvt_lexer.sv
// tokenizer state machine: mode, position and token start, record generation per byte
module kvt_lexer #(
    parameter int POS_BITS = kvt_pkg::POS_BITS_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic [7:0]       char_in,
    input  logic             last_char,
    output kvt_pkg::lex_out_t lex_out
);
    import kvt_pkg::*;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    mode_t               mode_reg,  mode_next,  mode_mid;
    logic [POS_BITS-1:0] pos_reg,   pos_next;
    logic [POS_BITS-1:0] start_reg, start_next, start_mid;
    logic [POS_BITS-1:0] pos_inc;
    logic                ovf, in_run, idle_path, end_content, nul_end, str_mode;
    logic [1:0]          n_c;
    rec_t [MAX_RESULTS-1:0] recs_c;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_ident(logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_UNDER) || (c == CH_DASH);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
    endfunction

    function automatic kind_t punct_kind(logic [7:0] c);
        kind_t k;
        case (c)
            CH_EQUAL: k = K_EQUAL;
            CH_COMMA: k = K_COMMA;
            CH_SEMI:  k = K_SEMI;
            default:  k = K_COLON;
        endcase
        return k;
    endfunction

    function automatic rec_t mk(kind_t k, logic h, logic [7:0] ch, logic d,
                                logic [POS_BITS-1:0] s, logic [POS_BITS-1:0] e, err_t er);
        rec_t r;
        r.kind        = k;
        r.has_char    = h;
        r.char_out    = ch;
        r.token_done  = d;
        r.start_pos   = POS_OUT_W'(s);
        r.end_pos     = POS_OUT_W'(e);
        r.error_code  = er;
        r.last_result = 1'b0;
        return r;
    endfunction

    assign ovf      = (pos_reg == POS_MAX);
    assign pos_inc  = pos_reg + 1'b1;
    assign in_run   = (mode_reg == MODE_NUMBER) ? is_digit(char_in) : is_ident(char_in);
    assign str_mode = (mode_reg == MODE_STRING) || (mode_reg == MODE_ESCAPE);
    assign nul_end  = !ovf && (char_in == CH_NUL) && (str_mode || idle_path);

    // next state
    always_comb begin
        mode_mid    = mode_reg;
        start_mid   = start_reg;
        idle_path   = 1'b0;
        end_content = 1'b0;
        if (ovf) begin
            end_content = 1'b1;
        end else begin
            unique case (mode_reg)
                MODE_NUMBER, MODE_IDENT: begin
                    if (!in_run) begin
                        mode_mid  = MODE_IDLE;
                        idle_path = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (char_in == CH_NUL) begin
                        end_content = 1'b1;
                    end else if (char_in == CH_QUOTE) begin
                        mode_mid = MODE_IDLE;
                    end else if (char_in == CH_BSLASH) begin
                        mode_mid = MODE_ESCAPE;
                    end
                end
                MODE_ESCAPE: begin
                    if (char_in == CH_NUL) begin
                        end_content = 1'b1;
                    end else begin
                        mode_mid = MODE_STRING;
                    end
                end
                MODE_IDLE: idle_path = 1'b1;
                default:   idle_path = 1'b1;
            endcase
            if (idle_path) begin
                if (char_in == CH_NUL) begin
                    end_content = 1'b1;
                end else if (char_in == CH_QUOTE) begin
                    mode_mid  = MODE_STRING;
                    start_mid = pos_reg;
                end else if (is_ident(char_in)) begin
                    mode_mid  = is_digit(char_in) ? MODE_NUMBER : MODE_IDENT;
                    start_mid = pos_reg;
                end
            end
            if (last_char) begin
                end_content = 1'b1;
            end
        end
        if (end_content) begin
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
        end else begin
            mode_next  = mode_mid;
            pos_next   = pos_inc;
            start_next = start_mid;
        end
    end

    // records
    always_comb begin
        n_c    = 2'd0;
        recs_c = '0;
        if (ovf) begin
            recs_c[0] = mk(K_ERROR, 1'b0, CH_NUL, 1'b0, POS_MAX, POS_MAX, ERR_OVERFLOW);
            recs_c[1] = mk(K_EOF, 1'b0, CH_NUL, 1'b1, POS_MAX, POS_MAX, ERR_NONE);
            n_c       = 2'd2;
        end else begin
            unique case (mode_reg)
                MODE_NUMBER, MODE_IDENT: begin
                    if (!in_run) begin
                        recs_c[n_c] = mk((mode_reg == MODE_NUMBER) ? K_NUMBER : K_IDENT,
                                         1'b0, CH_NUL, 1'b1, start_reg, pos_reg, ERR_NONE);
                    end else if (last_char) begin
                        recs_c[n_c] = mk((mode_reg == MODE_NUMBER) ? K_NUMBER : K_IDENT,
                                         1'b1, char_in, 1'b1, start_reg, pos_inc, ERR_NONE);
                    end else begin
                        recs_c[n_c] = mk((mode_reg == MODE_NUMBER) ? K_NUMBER : K_IDENT,
                                         1'b1, char_in, 1'b0, '0, '0, ERR_NONE);
                    end
                    n_c = n_c + 2'd1;
                end
                MODE_STRING, MODE_ESCAPE: begin
                    if (char_in == CH_NUL) begin
                        recs_c[n_c] = mk(K_ERROR, 1'b0, CH_NUL, 1'b0, start_reg, pos_reg,
                                         ERR_UNTERM);
                        n_c = n_c + 2'd1;
                        recs_c[n_c] = mk(K_EOF, 1'b0, CH_NUL, 1'b1, pos_reg, pos_reg, ERR_NONE);
                        n_c = n_c + 2'd1;
                    end else if (mode_reg == MODE_ESCAPE) begin
                        recs_c[n_c] = mk(K_DATA, 1'b1, char_in, 1'b0, '0, '0, ERR_NONE);
                        n_c = n_c + 2'd1;
                    end else if (char_in == CH_QUOTE) begin
                        recs_c[n_c] = mk(K_DATA, 1'b0, CH_NUL, 1'b1, start_reg, pos_inc,
                                         ERR_NONE);
                        n_c = n_c + 2'd1;
                    end else if (char_in != CH_BSLASH) begin
                        recs_c[n_c] = mk(K_DATA, 1'b1, char_in, 1'b0, '0, '0, ERR_NONE);
                        n_c = n_c + 2'd1;
                    end
                end
                MODE_IDLE: begin
                end
                default: begin
                end
            endcase
            if (idle_path) begin
                if (char_in == CH_NUL) begin
                    recs_c[n_c] = mk(K_EOF, 1'b0, CH_NUL, 1'b1, pos_reg, pos_reg, ERR_NONE);
                    n_c = n_c + 2'd1;
                end else if (is_space(char_in) || (char_in == CH_QUOTE)) begin
                    // nothing to emit
                end else if (is_ident(char_in)) begin
                    recs_c[n_c] = mk(is_digit(char_in) ? K_NUMBER : K_IDENT, 1'b1, char_in,
                                     last_char, last_char ? pos_reg : '0,
                                     last_char ? pos_inc : '0, ERR_NONE);
                    n_c = n_c + 2'd1;
                end else if ((char_in == CH_EQUAL) || (char_in == CH_COMMA) ||
                             (char_in == CH_SEMI) || (char_in == CH_COLON)) begin
                    recs_c[n_c] = mk(punct_kind(char_in), 1'b1, char_in, 1'b1, pos_reg,
                                     pos_inc, ERR_NONE);
                    n_c = n_c + 2'd1;
                end else begin
                    recs_c[n_c] = mk(K_ERROR, 1'b0, char_in, 1'b0, pos_reg, pos_inc,
                                     ERR_UNKNOWN);
                    n_c = n_c + 2'd1;
                end
            end
            if (last_char && !nul_end) begin
                if ((mode_mid == MODE_STRING) || (mode_mid == MODE_ESCAPE)) begin
                    recs_c[n_c] = mk(K_ERROR, 1'b0, CH_NUL, 1'b0, start_mid, pos_inc,
                                     ERR_UNTERM);
                    n_c = n_c + 2'd1;
                end
                recs_c[n_c] = mk(K_EOF, 1'b0, CH_NUL, 1'b1, pos_inc, pos_inc, ERR_NONE);
                n_c = n_c + 2'd1;
            end
        end
        if (n_c != 2'd0) begin
            recs_c[n_c - 2'd1].last_result = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
        end else if (in_fire) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
        end
    end

    assign lex_out.valid = in_fire;
    assign lex_out.count = n_c;
    assign lex_out.recs  = recs_c;

    a_last_resets_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && last_char |=> (pos_reg == '0) && (mode_reg == MODE_IDLE))
        else $error("position not cleared after end of content");

    a_last_gives_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && last_char |-> (n_c != 2'd0))
        else $error("end of content produced no record");

    a_ovf_two_recs: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && ovf |-> (n_c == 2'd2))
        else $error("index overflow did not give error and eof");

endmodule

FILE: rtl/kvt_out_queue.sv
// shift queue that takes up to three records at once and drains one per beat
module kvt_out_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  kvt_pkg::lex_out_t push,
    input  logic              pop,
    output kvt_pkg::rec_t     head,
    output logic              not_empty,
    output logic              has_room
);
    import kvt_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    rec_t [QUEUE_DEPTH-1:0] q_reg,   q_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       kept;
    logic [CNT_W-1:0]       push_cnt;

    assign push_cnt = push.valid ? CNT_W'(push.count) : '0;
    assign kept     = cnt_reg - CNT_W'(pop);
    assign cnt_next = kept + push_cnt;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (CNT_W'(i) < kept) begin
                q_next[i] = q_reg[IDX_W'(i) + IDX_W'(pop)];
            end else if (CNT_W'(i) - kept < push_cnt) begin
                q_next[i] = push.recs[2'(CNT_W'(i) - kept)];
            end else begin
                q_next[i] = q_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign head      = q_reg[0];
    assign not_empty = (cnt_reg != '0);
    assign has_room  = (cnt_reg <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> has_room)
        else $error("records pushed without room");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push.valid |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("pop did not shrink the queue");

endmodule

FILE: rtl/key_value_tokenizer.sv
// top level of the streaming key/value tokenizer
// Takes one content byte per beat on the s_ side (s_tlast marks the final byte) and emits
// token records on the m_ side. Whitespace is skipped; quoted strings come out byte by byte
// as data without their quotes, with backslash escapes removed; digit runs, identifier runs
// and the punctuation bytes = , ; : come out tagged with their kind, and each closed token
// gets a record carrying its start and end index. A zero byte or the tlast byte ends the
// content with an eof record and restarts indexing at 0. Unknown bytes, unterminated strings
// and index overflow come out as error records. The lexer turns each accepted byte into zero
// to three records; records sit in a four-entry queue and leave one per beat, so bytes giving
// at most one record each stream at one byte per cycle while m_tready stays high, and a byte
// giving two or three records holds s_tready low while they drain. s_tready depends only
// on the queue fill (one record or fewer held), not on m_tready.
module key_value_tokenizer #(
    parameter int POS_BITS = kvt_pkg::POS_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input beat
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] char_in
    input  logic                         s_tlast,   // last_char
    // result beat
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [kvt_pkg::TDATA_W-1:0]  m_tdata,   // [0] has_char, [8:1] char_out,
                                                    // [9] token_done, [25:10] start_pos,
                                                    // [41:26] end_pos, [43:42] error_code,
                                                    // [47:44] zero
    output logic [kvt_pkg::TUSER_W-1:0]  m_tuser,   // [3:0] kind
    output logic                         m_tlast    // last_result
);
    import kvt_pkg::*;

    logic     in_fire;
    logic     out_fire;
    logic     room;
    lex_out_t lex_out;
    rec_t     head;

    assign s_tready = room;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // per-byte lexing and position tracking
    kvt_lexer #(
        .POS_BITS (POS_BITS)
    ) u_lexer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .char_in   (s_tdata),
        .last_char (s_tlast),
        .lex_out   (lex_out)
    );

    // record queue decoupling the two sides
    kvt_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (lex_out),
        .pop       (out_fire),
        .head      (head),
        .not_empty (m_tvalid),
        .has_room  (room)
    );

    // pack the head record onto the result beat
    assign m_tdata = {4'b0000, head.error_code, head.end_pos, head.start_pos,
                      head.token_done, head.char_out, head.has_char};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_result;

endmodule

FILE: tb/key_value_tokenizer_tb.sv
// self-checking testbench for the key/value tokenizer: directed and random text, stalls
module key_value_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kvt_pkg::*;

    localparam int          POS_W       = POS_BITS_DEFAULT;
    localparam int unsigned POS_MAX     = (32'd1 << POS_W) - 1;
    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam int          RAND_BYTES  = 128;
    localparam int          TAIL_CYCLES = 20;

    // character ranges used by the run classifier
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UZ = 8'h5A;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LZ = 8'h7A;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         drain;   // hold the sender until every record has come back
    } byte_item_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'h00;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [TUSER_W-1:0]  m_tuser;
    logic                m_tlast;

    byte_item_t  pending_q[$];
    rec_t        token_q[$];     // records the tokenizer still owes, oldest first
    rec_t        step_recs[$];

    // tokenizer state as the checker sees it
    mode_t       lex_mode  = MODE_IDLE;
    int unsigned cur_pos   = 0;
    int unsigned tok_start = 0;

    int          recs_predicted = 0;
    int          recs_checked   = 0;
    int          bytes_accepted = 0;
    int          eof_seen       = 0;
    int          errors_seen    = 0;
    int          mismatch_cnt   = 0;
    int          cycle_cnt      = 0;
    int          burst_left     = 0;
    int          gap_left       = 0;
    int          ready_style    = 0;
    int          ready_left     = 0;
    logic [15:0] ready_pat      = 16'hFFFF;

    key_value_tokenizer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_word(logic [7:0] c);
        return is_digit(c) || (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
               c == CH_UNDER || c == CH_DASH;
    endfunction

    function automatic void put_rec(kind_t k, logic has, logic [7:0] c, logic done,
                                    int unsigned s, int unsigned e, err_t er);
        rec_t r;
        r.kind        = k;
        r.has_char    = has;
        r.char_out    = c;
        r.token_done  = done;
        r.start_pos   = s[POS_OUT_W-1:0];
        r.end_pos     = e[POS_OUT_W-1:0];
        r.error_code  = er;
        r.last_result = 1'b0;
        step_recs.insert(step_recs.size(), r);
    endfunction

    // work out the records one accepted byte causes and queue them
    function automatic void tokenize_byte(logic [7:0] c, logic last);
        int unsigned p;
        bit          taken;
        bit          ended;
        kind_t       k;
        p     = cur_pos;
        taken = 0;
        ended = 0;
        step_recs.delete();
        if (p >= POS_MAX) begin
            // index space used up: any open token is dropped
            put_rec(K_ERROR, 0, 0, 0, POS_MAX, POS_MAX, ERR_OVERFLOW);
            put_rec(K_EOF, 0, 0, 1, POS_MAX, POS_MAX, ERR_NONE);
            ended = 1;
        end else begin
            if (lex_mode == MODE_NUMBER || lex_mode == MODE_IDENT) begin
                k = (lex_mode == MODE_NUMBER) ? K_NUMBER : K_IDENT;
                if ((lex_mode == MODE_NUMBER) ? is_digit(c) : is_word(c)) begin
                    if (last) put_rec(k, 1, c, 1, tok_start, p + 1, ERR_NONE);
                    else      put_rec(k, 1, c, 0, 0, 0, ERR_NONE);
                    taken = 1;
                end else begin
                    // run closed by a foreign byte, which is then handled from idle
                    put_rec(k, 0, 0, 1, tok_start, p, ERR_NONE);
                    lex_mode = MODE_IDLE;
                end
            end else if (lex_mode == MODE_STRING || lex_mode == MODE_ESCAPE) begin
                taken = 1;
                if (c == CH_NUL) begin
                    put_rec(K_ERROR, 0, 0, 0, tok_start, p, ERR_UNTERM);
                    put_rec(K_EOF, 0, 0, 1, p, p, ERR_NONE);
                    ended = 1;
                end else if (lex_mode == MODE_ESCAPE) begin
                    put_rec(K_DATA, 1, c, 0, 0, 0, ERR_NONE);
                    lex_mode = MODE_STRING;
                end else if (c == CH_QUOTE) begin
                    put_rec(K_DATA, 0, 0, 1, tok_start, p + 1, ERR_NONE);
                    lex_mode = MODE_IDLE;
                end else if (c == CH_BSLASH) begin
                    lex_mode = MODE_ESCAPE;
                end else begin
                    put_rec(K_DATA, 1, c, 0, 0, 0, ERR_NONE);
                end
            end

            if (!taken) begin
                if (c == CH_NUL) begin
                    put_rec(K_EOF, 0, 0, 1, p, p, ERR_NONE);
                    ended = 1;
                end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
                    // whitespace gives nothing
                end else if (c == CH_QUOTE) begin
                    lex_mode  = MODE_STRING;
                    tok_start = p;
                end else if (is_word(c)) begin
                    k         = is_digit(c) ? K_NUMBER : K_IDENT;
                    lex_mode  = is_digit(c) ? MODE_NUMBER : MODE_IDENT;
                    tok_start = p;
                    if (last) put_rec(k, 1, c, 1, p, p + 1, ERR_NONE);
                    else      put_rec(k, 1, c, 0, 0, 0, ERR_NONE);
                end else if (c == CH_EQUAL || c == CH_COMMA || c == CH_SEMI || c == CH_COLON) begin
                    case (c)
                        CH_EQUAL: k = K_EQUAL;
                        CH_COMMA: k = K_COMMA;
                        CH_SEMI:  k = K_SEMI;
                        default:  k = K_COLON;
                    endcase
                    put_rec(k, 1, c, 1, p, p + 1, ERR_NONE);
                end else begin
                    put_rec(K_ERROR, 0, c, 0, p, p + 1, ERR_UNKNOWN);
                end
            end

            if (last && !ended) begin
                if (lex_mode == MODE_STRING || lex_mode == MODE_ESCAPE)
                    put_rec(K_ERROR, 0, 0, 0, tok_start, p + 1, ERR_UNTERM);
                put_rec(K_EOF, 0, 0, 1, p + 1, p + 1, ERR_NONE);
                ended = 1;
            end
        end

        if (ended) begin
            lex_mode  = MODE_IDLE;
            cur_pos   = 0;
            tok_start = 0;
        end else begin
            cur_pos = p + 1;
        end

        if (step_recs.size() > 0)
            step_recs[step_recs.size()-1].last_result = 1'b1;
        foreach (step_recs[i]) begin
            if (step_recs[i].kind == K_EOF)   eof_seen++;
            if (step_recs[i].kind == K_ERROR) errors_seen++;
            token_q.insert(token_q.size(), step_recs[i]);
        end
        recs_predicted += step_recs.size();
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // ---------------- stimulus building ----------------

    function automatic void push_byte(logic [7:0] c, logic last);
        byte_item_t it;
        it.ch    = c;
        it.last  = last;
        it.drain = 0;
        pending_q.insert(pending_q.size(), it);
    endfunction

    function automatic void push_drain();
        byte_item_t it;
        it.ch    = CH_NUL;
        it.last  = 0;
        it.drain = 1;
        pending_q.insert(pending_q.size(), it);
    endfunction

    // last marks the final byte of the string when set
    function automatic void push_text(string s, logic last);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], last && (i == s.len() - 1));
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_word_char(bit first);
        case ($urandom_range(0, first ? 5 : 7))
            0:       return CH_UNDER;
            1:       return CH_DASH;
            6, 7:    return CH_0 + 8'($urandom_range(0, 9));
            default: return rand_letter();
        endcase
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(0, 3))
            0:       return CH_TAB;
            1:       return CH_LF;
            default: return CH_SPACE;
        endcase
    endfunction

    // one content byte of a quoted string, quote and backslash excluded
    function automatic logic [7:0] rand_string_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if (c == CH_QUOTE || c == CH_BSLASH) c = CH_UNDER;
        return c;
    endfunction

    // a mostly well-formed key/value content with some noise, returns its byte count
    function automatic int gen_content();
        logic [7:0] text_q[$];
        int         n_tok;
        logic       end_last;
        n_tok = $urandom_range(1, 6);
        for (int t = 0; t < n_tok; t++) begin
            repeat ($urandom_range(0, 2)) text_q.insert(text_q.size(), rand_space());
            case ($urandom_range(0, 9))
                0, 1: begin
                    text_q.insert(text_q.size(), rand_word_char(1));
                    repeat ($urandom_range(0, 4))
                        text_q.insert(text_q.size(), rand_word_char(0));
                end
                2, 3: begin
                    repeat ($urandom_range(1, 4))
                        text_q.insert(text_q.size(), CH_0 + 8'($urandom_range(0, 9)));
                end
                4, 5: begin
                    text_q.insert(text_q.size(), CH_QUOTE);
                    repeat ($urandom_range(0, 4)) begin
                        if ($urandom_range(0, 4) == 0) begin
                            text_q.insert(text_q.size(), CH_BSLASH);
                            text_q.insert(text_q.size(), 8'($urandom_range(1, 255)));
                        end else begin
                            text_q.insert(text_q.size(), rand_string_char());
                        end
                    end
                    text_q.insert(text_q.size(), CH_QUOTE);
                end
                6, 7, 8: begin
                    case ($urandom_range(0, 3))
                        0:       text_q.insert(text_q.size(), CH_EQUAL);
                        1:       text_q.insert(text_q.size(), CH_COMMA);
                        2:       text_q.insert(text_q.size(), CH_SEMI);
                        default: text_q.insert(text_q.size(), CH_COLON);
                    endcase
                end
                default: text_q.insert(text_q.size(), 8'($urandom_range(1, 255)));
            endcase
        end

        // how the content ends
        end_last = 1;
        case ($urandom_range(0, 5))
            0: begin
                text_q.insert(text_q.size(), CH_NUL);
                end_last = 1'($urandom_range(0, 1));
            end
            1: begin
                // string left open at the end
                text_q.insert(text_q.size(), CH_QUOTE);
                repeat ($urandom_range(0, 2)) text_q.insert(text_q.size(), rand_string_char());
                if ($urandom_range(0, 1)) text_q.insert(text_q.size(), CH_BSLASH);
                if ($urandom_range(0, 1)) begin
                    text_q.insert(text_q.size(), CH_NUL);
                    end_last = 1'($urandom_range(0, 1));
                end
            end
            default: ;
        endcase

        foreach (text_q[i])
            push_byte(text_q[i], end_last && (i == text_q.size() - 1));
        return text_q.size();
    endfunction

    // ---------------- driver ----------------

    always @(posedge aclk) begin : driver
        byte_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                tokenize_byte(s_tdata, s_tlast);
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_q.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (pending_q[0].drain) begin
                    // pause until the tokenizer has handed back everything
                    s_tvalid <= 1'b0;
                    if (recs_checked == recs_predicted) void'(pending_q.pop_front());
                end else begin
                    nxt = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.ch;
                    s_tlast  <= nxt.last;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                    end
                end
            end
        end
    end

    // ---------------- receiver back-pressure ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (ready_left == 0) begin
            ready_style = $urandom_range(0, 2);
            ready_left  = $urandom_range(32, 200);
            ready_pat   = 16'($urandom);
            m_tready   <= 1'b1;
        end else begin
            ready_left--;
            case (ready_style)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 99) >= 35);
                default: begin
                    m_tready <= ready_pat[0];
                    ready_pat = {ready_pat[0], ready_pat[15:1]};
                end
            endcase
        end
    end

    // ---------------- monitor ----------------

    always @(posedge aclk) begin : monitor
        rec_t want_rec;
        if (aresetn && m_tvalid && m_tready) begin
            recs_checked <= recs_checked + 1;
            if (token_q.size() == 0) begin
                $error("record beat with none expected: kind %0d tdata %h", m_tuser, m_tdata);
                mismatch_cnt++;
            end else begin
                want_rec = token_q.pop_front();
                check_field("kind",        32'(want_rec.kind),        32'(m_tuser));
                check_field("has_char",    32'(want_rec.has_char),    32'(m_tdata[0]));
                check_field("char_out",    32'(want_rec.char_out),    32'(m_tdata[8:1]));
                check_field("token_done",  32'(want_rec.token_done),  32'(m_tdata[9]));
                check_field("start_pos",   32'(want_rec.start_pos),   32'(m_tdata[25:10]));
                check_field("end_pos",     32'(want_rec.end_pos),     32'(m_tdata[41:26]));
                check_field("error_code",  32'(want_rec.error_code),  32'(m_tdata[43:42]));
                check_field("last_result", 32'(want_rec.last_result), 32'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $error("run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        int rand_bytes;
        rand_bytes = 0;

        // directed: every kind, escapes, whitespace, unknown byte, runs closed by tlast
        push_text("k_1-x=42,\"a\\\"b\";: \t\n", 0);
        push_byte(8'hFF, 0);
        push_text("9", 1);
        // zero byte while an escape is pending, then a string cut off by tlast
        push_text("\"\\", 0);
        push_byte(CH_NUL, 0);
        push_text("\"z", 1);
        // run closed by a zero byte that is also marked last
        push_text("-", 0);
        push_byte(CH_NUL, 1);
        // identifier closed by a quote that opens a string on the last byte
        push_text("_7\"", 1);
        push_drain();

        while (rand_bytes < RAND_BYTES) begin
            rand_bytes += gen_content();
            if (rand_bytes >= RAND_BYTES / 2 && rand_bytes < RAND_BYTES / 2 + 12) push_drain();
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid) @(posedge aclk);
        @(posedge aclk);
        while (token_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (token_q.size() != 0) begin
            $error("%0d records never came out", token_q.size());
            mismatch_cnt++;
        end

        $display("run covered %0d input bytes and %0d record beats,", bytes_accepted,
                 recs_checked);
        $display("  with %0d contents closed and %0d error records", eof_seen, errors_seen);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
